/* rtl/core/hpma_pkg.sv */
// ----------------------------------------------------------------------------
// hpma_pkg
// Shared types and constants for the hall period moving-average meter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hpma_pkg;

    localparam int TIMER_W   = 16;
    localparam int CODE_W    = 3;
    localparam int AVG_DEPTH = 8;
    localparam int AVG_SHIFT = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 0;
    localparam int TOTAL_W   = TIMER_W + AVG_SHIFT;

    // floor(x / AVG_DEPTH) == (x * AVG_MUL) >> AVG_POS for any x < 2**TOTAL_W
    localparam int AVG_MUL_W = TOTAL_W + 1;
    localparam int AVG_POS   = TOTAL_W + AVG_SHIFT;
    localparam longint AVG_MUL_L =
        ((64'd1 << AVG_POS) + longint'(AVG_DEPTH) - 64'd1) / longint'(AVG_DEPTH);
    localparam logic [AVG_MUL_W-1:0] AVG_MUL = AVG_MUL_W'(AVG_MUL_L);
    localparam int PROD_W = TOTAL_W + AVG_MUL_W;

    localparam logic [CODE_W-1:0] HALL_ALL_LOW  = 3'b000;
    localparam logic [CODE_W-1:0] HALL_ALL_HIGH = 3'b111;

    typedef logic [TIMER_W-1:0] t_period;
    typedef logic [TOTAL_W-1:0] t_total;

    typedef struct packed {
        logic    legal;
        logic    edge_seen;
        t_period period;
    } t_hall_evt;

endpackage

/* rtl/core/hpma_cell.sv */
// ----------------------------------------------------------------------------
// hpma_cell
// One slot of the period history; takes its neighbor's period on each edge.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hpma_cell (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_shift,
    input  hpma_pkg::t_period i_period,
    output hpma_pkg::t_period o_period
);

    hpma_pkg::t_period r_period;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= '0;
        end else if (i_shift) begin
            r_period <= i_period;
        end
    end

    assign o_period = r_period;

endmodule

/* rtl/core/hpma_edge_det.sv */
// ----------------------------------------------------------------------------
// hpma_edge_det
// Hall code check, commutation edge detect and period measurement.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hpma_edge_det (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_accept,
    input  logic [hpma_pkg::CODE_W-1:0]      i_code,
    input  hpma_pkg::t_period                i_timer,
    output hpma_pkg::t_hall_evt              o_evt
);

    logic [hpma_pkg::CODE_W-1:0] r_prev_code;
    hpma_pkg::t_period           r_last_time;
    hpma_pkg::t_period           r_latest;
    logic                        legal;
    logic                        edge_hit;
    hpma_pkg::t_period           diff;

    always_comb begin
        legal    = (i_code != hpma_pkg::HALL_ALL_LOW) && (i_code != hpma_pkg::HALL_ALL_HIGH);
        edge_hit = legal && (i_code != r_prev_code);
        diff     = i_timer - r_last_time;
        o_evt.legal     = legal;
        o_evt.edge_seen = edge_hit;
        o_evt.period    = edge_hit ? diff : r_latest;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_code <= hpma_pkg::HALL_ALL_LOW;
            r_last_time <= '0;
            r_latest    <= '0;
        end else if (i_accept && edge_hit) begin
            r_prev_code <= i_code;
            r_last_time <= i_timer;
            r_latest    <= diff;
        end
    end

endmodule

/* rtl/core/hall_period_moving_average.sv */
// ----------------------------------------------------------------------------
// hall_period_moving_average
// Hall commutation period meter with a moving average over the last periods.
// ----------------------------------------------------------------------------
// channel | direction | handshake           | payload
// input   | in        | i_valid / o_stall   | i_hall_u i_hall_v i_hall_w i_timer_count
// output  | out       | o_valid / i_stall   | o_state_valid o_edge_seen o_period_us
//         |           |                     | o_avg_period_us
//
// One item per clock while the output is not stalled; each taken item is registered in
// the edge/history stage, then in the reciprocal-multiply average stage.
// The period history is a chain of AVG_DEPTH cells shifted on each edge.
// Reset is synchronous and clears all history; no clearing pass is needed.
// A stalled output holds; the input stalls only when both stages are full.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hall_period_moving_average (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_hall_u,
    input  logic        i_hall_v,
    input  logic        i_hall_w,
    input  logic [15:0] i_timer_count,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_state_valid,
    output logic        o_edge_seen,
    output logic [15:0] o_period_us,
    output logic [15:0] o_avg_period_us
);

    hpma_pkg::t_hall_evt evt;
    hpma_pkg::t_period   chain [hpma_pkg::AVG_DEPTH+1];
    logic                accept;
    logic                shift;
    logic                out_load;
    logic                a_load;

    hpma_pkg::t_total    r_total;
    hpma_pkg::t_total    n_total;

    logic                r_a_valid;
    logic                r_a_legal;
    logic                r_a_edge;
    hpma_pkg::t_period   r_a_period;
    hpma_pkg::t_total    r_a_total;

    logic                r_o_valid;
    logic                r_o_legal;
    logic                r_o_edge;
    hpma_pkg::t_period   r_o_period;
    hpma_pkg::t_period   r_o_avg;

    logic [hpma_pkg::PROD_W-1:0] prod;

    assign out_load = !r_o_valid || !i_stall;
    assign o_stall  = r_a_valid && !out_load;
    assign accept   = i_valid && !o_stall;
    assign a_load   = accept || out_load;
    assign shift    = accept && evt.edge_seen;

    hpma_edge_det u_edge (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_code   ({i_hall_u, i_hall_v, i_hall_w}),
        .i_timer  (i_timer_count),
        .o_evt    (evt)
    );

    assign chain[0] = evt.period;

    for (genvar g = 0; g < hpma_pkg::AVG_DEPTH; g++) begin : g_cell
        hpma_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_shift  (shift),
            .i_period (chain[g]),
            .o_period (chain[g+1])
        );
    end

    // oldest period leaves the last cell as the new one enters the first
    assign n_total = r_total - hpma_pkg::TOTAL_W'(chain[hpma_pkg::AVG_DEPTH])
                   + hpma_pkg::TOTAL_W'(evt.period);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= '0;
        end else if (shift) begin
            r_total <= n_total;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (a_load) begin
            r_a_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_a_legal  <= evt.legal;
            r_a_edge   <= evt.edge_seen;
            r_a_period <= evt.period;
            r_a_total  <= shift ? n_total : r_total;
        end
    end

    assign prod = hpma_pkg::PROD_W'(r_a_total) * hpma_pkg::PROD_W'(hpma_pkg::AVG_MUL);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (out_load) begin
            r_o_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load && r_a_valid) begin
            r_o_legal  <= r_a_legal;
            r_o_edge   <= r_a_edge;
            r_o_period <= r_a_period;
            r_o_avg    <= prod[hpma_pkg::AVG_POS +: hpma_pkg::TIMER_W];
        end
    end

    assign o_valid         = r_o_valid;
    assign o_state_valid   = r_o_legal;
    assign o_edge_seen     = r_o_edge;
    assign o_period_us     = r_o_period;
    assign o_avg_period_us = r_o_avg;

endmodule

/* rtl/core/hpma_checker.sv */
// ----------------------------------------------------------------------------
// hpma_checker
// Port-level checks for the hall period moving-average meter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hpma_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic        i_hall_u,
    input logic        i_hall_v,
    input logic        i_hall_w,
    input logic [15:0] i_timer_count,
    input logic        o_valid,
    input logic        i_stall,
    input logic        o_state_valid,
    input logic        o_edge_seen,
    input logic [15:0] o_period_us,
    input logic [15:0] o_avg_period_us
);

    a_edge_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_edge_seen |-> o_state_valid)
        else $error("edge reported on an illegal hall code");

    a_no_stall_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> !o_stall)
        else $error("input stalled while output is empty");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_period_us)
            && $stable(o_avg_period_us) && $stable(o_edge_seen))
        else $error("stalled output item changed");

endmodule

bind hall_period_moving_average hpma_checker u_hpma_checker (.*);

/* verif/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Checks the hall period meter: a queue-fed driver sends hall samples in
// bursts, a stall pattern throttles the results, and every result is compared
// with a cycle-free model of the edge, period and ring-average behavior.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

    localparam int RANDOM_ITEMS   = 1330;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 8;

    // legal commutation order, forward rotation
    localparam logic [hpma_pkg::CODE_W-1:0] HALL_SEQ [6] = '{3'b001, 3'b011, 3'b010,
                                                              3'b110, 3'b100, 3'b101};

    typedef struct packed {
        logic [hpma_pkg::CODE_W-1:0] code;
        hpma_pkg::t_period           timer;
    } t_hall_sample;

    typedef struct packed {
        logic              state_valid;
        logic              edge_seen;
        hpma_pkg::t_period period_us;
        hpma_pkg::t_period avg_period_us;
    } t_hall_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        i_hall_u = 1'b0;
    logic        i_hall_v = 1'b0;
    logic        i_hall_w = 1'b0;
    logic [15:0] i_timer_count = '0;
    logic        i_stall = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic        o_state_valid;
    logic        o_edge_seen;
    logic [15:0] o_period_us;
    logic [15:0] o_avg_period_us;

    hall_period_moving_average u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_hall_u        (i_hall_u),
        .i_hall_v        (i_hall_v),
        .i_hall_w        (i_hall_w),
        .i_timer_count   (i_timer_count),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_state_valid   (o_state_valid),
        .o_edge_seen     (o_edge_seen),
        .o_period_us     (o_period_us),
        .o_avg_period_us (o_avg_period_us)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    t_hall_sample pending_samples [$];
    t_hall_result expected_results [$];
    int           errors = 0;

    // meter model state
    logic [hpma_pkg::CODE_W-1:0] last_code = '0;
    hpma_pkg::t_period           last_edge_time = '0;
    hpma_pkg::t_period           held_period = '0;
    hpma_pkg::t_period           period_ring [hpma_pkg::AVG_DEPTH] = '{default: '0};
    int                          ring_pos = 0;
    hpma_pkg::t_total            period_total = '0;

    function automatic t_hall_result hall_meter_step(logic [hpma_pkg::CODE_W-1:0] code,
                                                     hpma_pkg::t_period now);
        t_hall_result res;
        logic         legal;
        legal = (code != hpma_pkg::HALL_ALL_LOW) && (code != hpma_pkg::HALL_ALL_HIGH);
        res.state_valid = legal;
        res.edge_seen = legal && (code != last_code);
        if (res.edge_seen) begin
            held_period = now - last_edge_time;
            last_edge_time = now;
            last_code = code;
            period_total = period_total - period_ring[ring_pos] + held_period;
            period_ring[ring_pos] = held_period;
            ring_pos = (ring_pos == hpma_pkg::AVG_DEPTH - 1) ? 0 : ring_pos + 1;
        end
        res.period_us = held_period;
        res.avg_period_us = hpma_pkg::t_period'(period_total / hpma_pkg::AVG_DEPTH);
        return res;
    endfunction

    task automatic add_sample(logic [hpma_pkg::CODE_W-1:0] code, hpma_pkg::t_period timer);
        t_hall_sample s;
        s.code = code;
        s.timer = timer;
        pending_samples.push_back(s);
    endtask

    task automatic check_field(string name, logic [15:0] exp_val, logic [15:0] act_val);
        if (exp_val !== act_val) begin
            $display("%0t %s: expected %h actual %h", $time, name, exp_val, act_val);
            errors++;
        end
    endtask

    // driver: bursts with gaps on the input, rotating stall pattern on the output
    logic         in_taken = 1'b0;
    int           burst_left = 1;
    int           gap_left = 0;
    logic [15:0]  stall_pattern = '0;
    int           stall_phase = 0;

    always @(negedge i_clk) begin
        t_hall_sample s;
        logic [15:0]  next_pattern;
        if (i_rst_n && (!i_valid || in_taken)) begin
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                i_valid <= 1'b0;
            end else if (pending_samples.size() > 0) begin
                s = pending_samples.pop_front();
                {i_hall_u, i_hall_v, i_hall_w} <= s.code;
                i_timer_count <= s.timer;
                i_valid <= 1'b1;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 24);
                    case ($urandom_range(0, 9))
                        0, 1, 2, 3: gap_left <= 0;
                        4, 5, 6, 7: gap_left <= $urandom_range(1, 4);
                        8:          gap_left <= $urandom_range(5, 12);
                        default:    gap_left <= $urandom_range(20, 40);
                    endcase
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                i_valid <= 1'b0;
            end
        end

        if (stall_phase == 63) begin
            case ($urandom_range(0, 3))
                0:       next_pattern = '0;
                1:       next_pattern = 16'($urandom & $urandom);
                2:       next_pattern = 16'($urandom);
                default: next_pattern = 16'($urandom | $urandom);
            endcase
            next_pattern[0] = 1'b0;
        end else begin
            next_pattern = {stall_pattern[0], stall_pattern[15:1]};
        end
        stall_pattern <= next_pattern;
        stall_phase <= (stall_phase == 63) ? 0 : stall_phase + 1;
        i_stall <= next_pattern[0];
    end

    // monitor: predicts on accepted samples, checks accepted results, watchdog
    int idle_cycles = 0;

    always @(posedge i_clk) begin
        t_hall_result exp_res;
        logic         in_acc;
        logic         out_acc;
        in_acc = i_rst_n && i_valid && !o_stall;
        out_acc = i_rst_n && o_valid && !i_stall;
        in_taken <= in_acc;
        if (in_acc) begin
            expected_results.push_back(
                hall_meter_step({i_hall_u, i_hall_v, i_hall_w}, i_timer_count));
        end
        if (out_acc) begin
            if (expected_results.size() == 0) begin
                $display("%0t unexpected item: expected none actual %h %h %h %h", $time,
                         o_state_valid, o_edge_seen, o_period_us, o_avg_period_us);
                errors++;
            end else begin
                exp_res = expected_results.pop_front();
                check_field("state_valid", 16'(exp_res.state_valid), 16'(o_state_valid));
                check_field("edge_seen", 16'(exp_res.edge_seen), 16'(o_edge_seen));
                check_field("period_us", exp_res.period_us, o_period_us);
                check_field("avg_period_us", exp_res.avg_period_us, o_avg_period_us);
            end
        end
        if (i_rst_n) begin
            if (in_acc || out_acc) begin
                idle_cycles <= 0;
            end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
                $display("%0t watchdog: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("hall_period_moving_average: mismatch");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial begin
        int                idx;
        int                dir;
        int                seg_len;
        int                count;
        hpma_pkg::t_period now;

        // directed: illegal codes from reset, first edge from time zero,
        // repeats, zero and full-scale periods, full ring at max, timer wrap
        add_sample(hpma_pkg::HALL_ALL_LOW, 16'hFFFF);
        add_sample(hpma_pkg::HALL_ALL_HIGH, 16'h0000);
        add_sample(HALL_SEQ[0], 16'd100);
        add_sample(HALL_SEQ[0], 16'd200);
        add_sample(HALL_SEQ[1], 16'd300);
        add_sample(hpma_pkg::HALL_ALL_HIGH, 16'd400);
        add_sample(HALL_SEQ[2], 16'hFFFF);
        add_sample(HALL_SEQ[3], 16'hFFFF);
        add_sample(HALL_SEQ[4], 16'h7FFF);
        add_sample(HALL_SEQ[5], 16'hFFFE);
        for (int k = 0; k < 9; k++) begin
            add_sample(HALL_SEQ[k % 6], 16'hFFFD - 16'(k));
        end
        add_sample(HALL_SEQ[3], 16'h0010);
        add_sample(hpma_pkg::HALL_ALL_LOW, 16'h1234);
        add_sample(HALL_SEQ[3], 16'h2000);
        add_sample(HALL_SEQ[2], 16'h2001);

        // random: mostly rotation segments with occasional bounce and noise
        count = 0;
        idx = 0;
        now = 16'($urandom);
        while (count < RANDOM_ITEMS) begin
            if ($urandom_range(0, 4) == 0) begin
                seg_len = $urandom_range(1, 6);
                for (int k = 0; k < seg_len; k++) begin
                    add_sample(3'($urandom), 16'($urandom));
                end
            end else begin
                seg_len = $urandom_range(8, 40);
                dir = $urandom_range(0, 1) ? 1 : 5;
                for (int k = 0; k < seg_len; k++) begin
                    case ($urandom_range(0, 19))
                        0:       now = now + 16'($urandom_range(0, 65535));
                        1, 2:    now = now + 16'($urandom_range(0, 40));
                        default: now = now + 16'($urandom_range(1, 3000));
                    endcase
                    case ($urandom_range(0, 19))
                        0, 1: add_sample(HALL_SEQ[idx], now);
                        2:    add_sample($urandom_range(0, 1) ? hpma_pkg::HALL_ALL_LOW
                                                              : hpma_pkg::HALL_ALL_HIGH,
                                         now);
                        3: begin
                            idx = (idx + 6 - dir) % 6;
                            add_sample(HALL_SEQ[idx], now);
                        end
                        default: begin
                            idx = (idx + dir) % 6;
                            add_sample(HALL_SEQ[idx], now);
                        end
                    endcase
                end
            end
            count += seg_len;
        end

        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_samples.size() > 0 || i_valid) @(posedge i_clk);
        while (expected_results.size() > 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (errors == 0) begin
            $display("hall_period_moving_average: match");
        end else begin
            $display("hall_period_moving_average: mismatch");
        end
        $finish;
    end

endmodule

/* filelist.f */
rtl/core/hpma_pkg.sv
rtl/core/hpma_cell.sv
rtl/core/hpma_edge_det.sv
rtl/core/hall_period_moving_average.sv
rtl/core/hpma_checker.sv
verif/tb.sv
